// ----- src/tsvf_pkg.sv -----
// ----------------------------------------------------------------------------
// tsvf_pkg
// Shared widths, codes and the sequencer control word for the oversampled
// trapezoidal state variable filter.
// ----------------------------------------------------------------------------
package tsvf_pkg;

  localparam int SAMPLE_BITS = 24;
  localparam int OVERSAMPLE  = 2;

  localparam int STATE_W    = 32;
  localparam int COEF_W     = 18;
  localparam int MIX_W      = 24;
  localparam int COEF_FRAC  = 17;
  localparam int MIX_FRAC   = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = (MIX_W > COEF_W) ? MIX_W : COEF_W;

  // multiplier operands: A carries states, the input sample, x - state and split
  // node values, B carries coefficients (zero extended) and mix weights
  localparam int OPA_W  = ((SAMPLE_BITS > STATE_W) ? SAMPLE_BITS : STATE_W) + 1;
  localparam int OPB_W  = ((MIX_W > COEF_W + 1) ? MIX_W : COEF_W + 1);
  localparam int PROD_W = OPA_W + OPB_W;

  // band and low node values, split in two halves for the mix multiplies
  localparam int V_W   = 36;
  localparam int LO_W  = 19;
  localparam int HI_W  = V_W - LO_W;
  localparam int UPD_W = V_W + 2;
  localparam int ACC_W = 64;

  localparam int PASS_W = (OVERSAMPLE > 1) ? $clog2(OVERSAMPLE) : 1;
  localparam int STEP_W = 4;

  // sequencer steps of one pass; the last pass runs on through the mix
  localparam logic [STEP_W-1:0] STEP_V3      = 4'd0;
  localparam logic [STEP_W-1:0] STEP_A2V3    = 4'd1;
  localparam logic [STEP_W-1:0] STEP_A2I1    = 4'd2;
  localparam logic [STEP_W-1:0] STEP_V1      = 4'd3;
  localparam logic [STEP_W-1:0] STEP_I1      = 4'd4;
  localparam logic [STEP_W-1:0] STEP_V2_RND  = 4'd5;
  localparam logic [STEP_W-1:0] STEP_V2_ADD  = 4'd6;
  localparam logic [STEP_W-1:0] STEP_I2      = 4'd7;
  localparam logic [STEP_W-1:0] STEP_MIX_LO  = 4'd8;
  localparam logic [STEP_W-1:0] STEP_MIX_ACC = 4'd9;
  localparam logic [STEP_W-1:0] STEP_Y       = 4'd10;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_OUT
  } state_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COEF_A1   = 3'd0,
    REG_COEF_A2   = 3'd1,
    REG_COEF_A3   = 3'd2,
    REG_MIX_INPUT = 3'd3,
    REG_MIX_BAND  = 3'd4,
    REG_MIX_LOW   = 3'd5
  } cfg_reg_e;

  typedef enum logic [2:0] {
    OPA_I1,
    OPA_V3,
    OPA_X,
    OPA_V1_HI,
    OPA_V1_LO,
    OPA_V2_HI,
    OPA_V2_LO
  } opa_e;

  typedef enum logic [2:0] {
    OPB_A1,
    OPB_A2,
    OPB_A3,
    OPB_MIX_IN,
    OPB_MIX_BAND,
    OPB_MIX_LOW
  } opb_e;

  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_LOAD,
    ACC_ADD,
    ACC_ADD_HI
  } acc_e;

  typedef struct packed {
    opa_e opa;
    opb_e opb;
    acc_e acc_op;
    logic v3_wr;
    logic v1_wr;
    logic v2_rnd_wr;
    logic v2_add_wr;
    logic i1_wr;
    logic i2_wr;
    logic y_wr;
  } ctl_t;

endpackage

// ----- src/tsvf_cfg.sv -----
// ----------------------------------------------------------------------------
// tsvf_cfg
// Coefficient and mix weight registers with their write decode.
// ----------------------------------------------------------------------------
module tsvf_cfg
  import tsvf_pkg::*;
(
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]          cfg_index_i,
  input  logic [CFG_DATA_W-1:0]         cfg_data_i,
  output logic [COEF_W-1:0]             coef_a1_o,
  output logic [COEF_W-1:0]             coef_a2_o,
  output logic [COEF_W-1:0]             coef_a3_o,
  output logic signed [MIX_W-1:0]       mix_input_o,
  output logic signed [MIX_W-1:0]       mix_band_o,
  output logic signed [MIX_W-1:0]       mix_low_o
);

  logic [COEF_W-1:0]       coef_a1_q, coef_a1_d;
  logic [COEF_W-1:0]       coef_a2_q, coef_a2_d;
  logic [COEF_W-1:0]       coef_a3_q, coef_a3_d;
  logic signed [MIX_W-1:0] mix_input_q, mix_input_d;
  logic signed [MIX_W-1:0] mix_band_q, mix_band_d;
  logic signed [MIX_W-1:0] mix_low_q, mix_low_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    coef_a1_d   = coef_a1_q;
    coef_a2_d   = coef_a2_q;
    coef_a3_d   = coef_a3_q;
    mix_input_d = mix_input_q;
    mix_band_d  = mix_band_q;
    mix_low_d   = mix_low_q;
    if (cfg_valid_i) begin
      // drop writes beyond the last register
      unique case (cfg_index_i)
        REG_COEF_A1:   coef_a1_d   = cfg_data_i[COEF_W-1:0];
        REG_COEF_A2:   coef_a2_d   = cfg_data_i[COEF_W-1:0];
        REG_COEF_A3:   coef_a3_d   = cfg_data_i[COEF_W-1:0];
        REG_MIX_INPUT: mix_input_d = cfg_data_i[MIX_W-1:0];
        REG_MIX_BAND:  mix_band_d  = cfg_data_i[MIX_W-1:0];
        REG_MIX_LOW:   mix_low_d   = cfg_data_i[MIX_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_a1_q   <= COEF_W'(1 << COEF_FRAC);
      coef_a2_q   <= '0;
      coef_a3_q   <= '0;
      mix_input_q <= '0;
      mix_band_q  <= '0;
      mix_low_q   <= MIX_W'(1 << MIX_FRAC);
    end else begin
      coef_a1_q   <= coef_a1_d;
      coef_a2_q   <= coef_a2_d;
      coef_a3_q   <= coef_a3_d;
      mix_input_q <= mix_input_d;
      mix_band_q  <= mix_band_d;
      mix_low_q   <= mix_low_d;
    end
  end

  assign coef_a1_o   = coef_a1_q;
  assign coef_a2_o   = coef_a2_q;
  assign coef_a3_o   = coef_a3_q;
  assign mix_input_o = mix_input_q;
  assign mix_band_o  = mix_band_q;
  assign mix_low_o   = mix_low_q;

endmodule

// ----- src/tsvf_mac.sv -----
// ----------------------------------------------------------------------------
// tsvf_mac
// Shared multiply-accumulate unit: registered product, then accumulate.
// ----------------------------------------------------------------------------
module tsvf_mac
  import tsvf_pkg::*;
(
  input  logic                     clk_i,
  input  acc_e                     acc_op_i,
  input  logic signed [OPA_W-1:0]  opa_i,
  input  logic signed [OPB_W-1:0]  opb_i,
  output logic signed [ACC_W-1:0]  acc_o
);

  logic signed [PROD_W-1:0] prod_q, prod_d;
  logic signed [ACC_W-1:0]  acc_q, acc_d;
  logic signed [ACC_W-1:0]  prod_ext;

  assign prod_d   = opa_i * opb_i;
  assign prod_ext = ACC_W'(prod_q);

  always_comb begin
    case (acc_op_i)
      ACC_LOAD:   acc_d = prod_ext;
      ACC_ADD:    acc_d = acc_q + prod_ext;
      // upper half of a split node value weighs 2^LO_W
      ACC_ADD_HI: acc_d = acc_q + (prod_ext <<< LO_W);
      default:    acc_d = acc_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    acc_q  <= acc_d;
  end

  assign acc_o = acc_q;

endmodule

// ----- src/tsvf_seq.sv -----
// ----------------------------------------------------------------------------
// tsvf_seq
// Step sequencer: walks the passes of one word and issues the control word
// for the shared multiply-accumulate unit and the datapath registers.
// ----------------------------------------------------------------------------
module tsvf_seq
  import tsvf_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  output logic out_valid_o,
  input  logic out_ready_i,
  output ctl_t ctl_o
);

  state_e            state_q, state_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic [PASS_W-1:0] pass_q, pass_d;
  logic              last_pass;

  assign last_pass = (pass_q == PASS_W'(OVERSAMPLE - 1));

  // next state
  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    pass_d  = pass_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_RUN;
          step_d  = STEP_V3;
          pass_d  = '0;
        end
      end
      ST_RUN: begin
        if (last_pass && step_q == STEP_Y) begin
          state_d = ST_OUT;
        end else if (!last_pass && step_q == STEP_I2) begin
          // earlier passes end once both states are updated
          step_d = STEP_V3;
          pass_d = pass_q + PASS_W'(1);
        end else begin
          step_d = step_q + STEP_W'(1);
        end
      end
      ST_OUT: begin
        if (out_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready_o  = (state_q == ST_IDLE);
    out_valid_o = (state_q == ST_OUT);
    ctl_o.opa       = OPA_I1;
    ctl_o.opb       = OPB_A1;
    ctl_o.acc_op    = ACC_HOLD;
    ctl_o.v3_wr     = 1'b0;
    ctl_o.v1_wr     = 1'b0;
    ctl_o.v2_rnd_wr = 1'b0;
    ctl_o.v2_add_wr = 1'b0;
    ctl_o.i1_wr     = 1'b0;
    ctl_o.i2_wr     = 1'b0;
    ctl_o.y_wr      = 1'b0;
    if (state_q == ST_RUN) begin
      unique case (step_q)
        STEP_V3: begin
          ctl_o.opa   = OPA_I1;
          ctl_o.opb   = OPB_A1;
          ctl_o.v3_wr = 1'b1;
        end
        STEP_A2V3: begin
          ctl_o.opa    = OPA_V3;
          ctl_o.opb    = OPB_A2;
          ctl_o.acc_op = ACC_LOAD;
        end
        STEP_A2I1: begin
          ctl_o.opa    = OPA_I1;
          ctl_o.opb    = OPB_A2;
          ctl_o.acc_op = ACC_ADD;
        end
        STEP_V1: begin
          ctl_o.opa    = OPA_V3;
          ctl_o.opb    = OPB_A3;
          ctl_o.acc_op = ACC_LOAD;
          ctl_o.v1_wr  = 1'b1;
        end
        STEP_I1: begin
          ctl_o.opa    = OPA_X;
          ctl_o.opb    = OPB_MIX_IN;
          ctl_o.acc_op = ACC_ADD;
          ctl_o.i1_wr  = 1'b1;
        end
        STEP_V2_RND: begin
          ctl_o.opa       = OPA_V1_HI;
          ctl_o.opb       = OPB_MIX_BAND;
          ctl_o.acc_op    = ACC_LOAD;
          ctl_o.v2_rnd_wr = 1'b1;
        end
        STEP_V2_ADD: begin
          ctl_o.opa       = OPA_V1_LO;
          ctl_o.opb       = OPB_MIX_BAND;
          ctl_o.acc_op    = ACC_ADD_HI;
          ctl_o.v2_add_wr = 1'b1;
        end
        STEP_I2: begin
          ctl_o.opa    = OPA_V2_HI;
          ctl_o.opb    = OPB_MIX_LOW;
          ctl_o.acc_op = ACC_ADD;
          ctl_o.i2_wr  = 1'b1;
        end
        STEP_MIX_LO: begin
          ctl_o.opa    = OPA_V2_LO;
          ctl_o.opb    = OPB_MIX_LOW;
          ctl_o.acc_op = ACC_ADD_HI;
        end
        STEP_MIX_ACC: begin
          ctl_o.acc_op = ACC_ADD;
        end
        STEP_Y: begin
          ctl_o.y_wr = 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= STEP_V3;
      pass_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      pass_q  <= pass_d;
    end
  end

`ifndef NO_ASSERTIONS
  a_pass_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pass_q <= PASS_W'(OVERSAMPLE - 1))
    else $error("pass counter beyond last pass");

  a_step_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_RUN |-> step_q <= STEP_Y)
    else $error("step counter beyond final step");

  a_y_to_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RUN && step_q == STEP_Y) |=> out_valid_o)
    else $error("result not presented after final step");
`endif

endmodule

// ----- src/trapezoidal_svf_oversampled_core.sv -----
// ----------------------------------------------------------------------------
// trapezoidal_svf_oversampled_core
// Two-pass trapezoidal state variable filter on a shared multiplier.
// ----------------------------------------------------------------------------
// A word is accepted in the idle state and then runs OVERSAMPLE passes. Each
// pass issues its multiplies one per cycle through the single 33 x 24 bit
// multiply-accumulate unit (8 steps for an early pass, 11 for the last, which
// also forms the output mix); the result is then held until it is taken.
// The block takes one word at a time: in_ready_o is high only while no word
// is being filtered or waiting on the output. Coefficients are to be written
// through the cfg port only while the block is idle; the block itself does
// not enforce this.
module trapezoidal_svf_oversampled_core
  import tsvf_pkg::*;
(
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]          cfg_index_i,
  input  logic [CFG_DATA_W-1:0]         cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic signed [SAMPLE_BITS-1:0] sample_in_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [SAMPLE_BITS-1:0] sample_out_o,
  output logic                          clipped_o
);

  localparam logic signed [UPD_W-1:0] ST_HI =
    (UPD_W'(1) <<< (STATE_W - 1)) - UPD_W'(1);
  localparam logic signed [UPD_W-1:0] ST_LO = -ST_HI - UPD_W'(1);
  localparam logic signed [ACC_W-1:0] Y_HI =
    (ACC_W'(1) <<< (SAMPLE_BITS - 1)) - ACC_W'(1);
  localparam logic signed [ACC_W-1:0] Y_LO = -Y_HI - ACC_W'(1);

  ctl_t ctl;

  logic [COEF_W-1:0]       coef_a1, coef_a2, coef_a3;
  logic signed [MIX_W-1:0] mix_input, mix_band, mix_low;

  logic signed [OPA_W-1:0] opa;
  logic signed [OPB_W-1:0] opb;
  logic signed [ACC_W-1:0] acc;

  logic signed [SAMPLE_BITS-1:0] x_q;
  logic signed [OPA_W-1:0]       v3_q;
  logic signed [V_W-1:0]         v1_q, v2_q;
  logic signed [STATE_W-1:0]     i1_q, i2_q;
  logic                          hit_q;
  logic signed [SAMPLE_BITS-1:0] sample_out_q;
  logic                          clipped_q;

  logic                          in_accept;
  logic signed [ACC_W-1:0]       coef_rnd_sum, coef_rnd;
  logic signed [V_W-1:0]         v_rnd;
  logic signed [UPD_W-1:0]       upd_v, upd_s, upd;
  logic signed [STATE_W-1:0]     upd_sat;
  logic                          upd_hit;
  logic signed [ACC_W-1:0]       y_rnd_sum, y_full;
  logic signed [SAMPLE_BITS-1:0] y_sat;
  logic                          y_hit;

  tsvf_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .coef_a1_o   (coef_a1),
    .coef_a2_o   (coef_a2),
    .coef_a3_o   (coef_a3),
    .mix_input_o (mix_input),
    .mix_band_o  (mix_band),
    .mix_low_o   (mix_low)
  );

  tsvf_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .ctl_o       (ctl)
  );

  tsvf_mac u_mac (
    .clk_i    (clk_i),
    .acc_op_i (ctl.acc_op),
    .opa_i    (opa),
    .opb_i    (opb),
    .acc_o    (acc)
  );

  assign in_accept = in_valid_i && in_ready_o;

  // operand select for the shared multiplier
  always_comb begin
    case (ctl.opa)
      OPA_I1:    opa = OPA_W'(i1_q);
      OPA_V3:    opa = v3_q;
      OPA_X:     opa = OPA_W'(x_q);
      OPA_V1_HI: opa = OPA_W'($signed(v1_q[V_W-1:LO_W]));
      OPA_V1_LO: opa = OPA_W'(v1_q[LO_W-1:0]);
      OPA_V2_HI: opa = OPA_W'($signed(v2_q[V_W-1:LO_W]));
      OPA_V2_LO: opa = OPA_W'(v2_q[LO_W-1:0]);
      default:   opa = '0;
    endcase
  end

  always_comb begin
    case (ctl.opb)
      OPB_A1:       opb = OPB_W'(coef_a1);
      OPB_A2:       opb = OPB_W'(coef_a2);
      OPB_A3:       opb = OPB_W'(coef_a3);
      OPB_MIX_IN:   opb = OPB_W'(mix_input);
      OPB_MIX_BAND: opb = OPB_W'(mix_band);
      OPB_MIX_LOW:  opb = OPB_W'(mix_low);
      default:      opb = '0;
    endcase
  end

  // round half up on the coefficient fraction
  assign coef_rnd_sum = acc + (ACC_W'(1) <<< (COEF_FRAC - 1));
  assign coef_rnd     = coef_rnd_sum >>> COEF_FRAC;
  assign v_rnd        = coef_rnd[V_W-1:0];

  // one saturating state update, shared by both integrators
  always_comb begin
    if (ctl.i2_wr) begin
      upd_v = UPD_W'(v2_q);
      upd_s = UPD_W'(i2_q);
    end else begin
      upd_v = UPD_W'(v1_q);
      upd_s = UPD_W'(i1_q);
    end
    upd = (upd_v <<< 1) - upd_s;
    if (upd > ST_HI) begin
      upd_sat = ST_HI[STATE_W-1:0];
      upd_hit = 1'b1;
    end else if (upd < ST_LO) begin
      upd_sat = ST_LO[STATE_W-1:0];
      upd_hit = 1'b1;
    end else begin
      upd_sat = upd[STATE_W-1:0];
      upd_hit = 1'b0;
    end
  end

  assign y_rnd_sum = acc + (ACC_W'(1) <<< (MIX_FRAC - 1));
  assign y_full    = y_rnd_sum >>> MIX_FRAC;

  always_comb begin
    if (y_full > Y_HI) begin
      y_sat = Y_HI[SAMPLE_BITS-1:0];
      y_hit = 1'b1;
    end else if (y_full < Y_LO) begin
      y_sat = Y_LO[SAMPLE_BITS-1:0];
      y_hit = 1'b1;
    end else begin
      y_sat = y_full[SAMPLE_BITS-1:0];
      y_hit = 1'b0;
    end
  end

  // datapath payload
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      x_q <= sample_in_i;
    end
    if (ctl.v3_wr) begin
      v3_q <= OPA_W'(x_q) - OPA_W'(i2_q);
    end
    if (ctl.v1_wr) begin
      v1_q <= v_rnd;
    end
    if (ctl.v2_rnd_wr) begin
      v2_q <= v_rnd;
    end else if (ctl.v2_add_wr) begin
      v2_q <= v2_q + V_W'(i2_q);
    end
    if (ctl.y_wr) begin
      sample_out_q <= y_sat;
      clipped_q    <= hit_q || y_hit;
    end
  end

  // integrator states and the clip flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      i1_q  <= '0;
      i2_q  <= '0;
      hit_q <= 1'b0;
    end else begin
      if (ctl.i1_wr) begin
        i1_q <= upd_sat;
      end
      if (ctl.i2_wr) begin
        i2_q <= upd_sat;
      end
      if (in_accept) begin
        hit_q <= 1'b0;
      end else if ((ctl.i1_wr || ctl.i2_wr) && upd_hit) begin
        hit_q <= 1'b1;
      end
    end
  end

  assign sample_out_o = sample_out_q;
  assign clipped_o    = clipped_q;

`ifndef NO_ASSERTIONS
  a_one_side: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("input ready while a result is pending");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> !in_ready_o)
    else $error("ready right after accepting a word");

  a_single_state_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ctl.i1_wr && ctl.i2_wr))
    else $error("both integrators written through the shared saturator");
`endif

endmodule
